// ===== rtl/trk_pkg.sv =====
// Shared types, command codes and register indexes for the trickle timer.
package trk_pkg;

    // Command codes carried in the low bits of an input word
    localparam logic [2:0] CMD_TICK         = 3'd0;
    localparam logic [2:0] CMD_START        = 3'd1;
    localparam logic [2:0] CMD_STOP         = 3'd2;
    localparam logic [2:0] CMD_INCONSISTENT = 3'd3;
    localparam logic [2:0] CMD_CONSISTENT   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_INTERVAL_MIN = 2'd0;
    localparam logic [1:0] REG_DOUBLINGS    = 2'd1;
    localparam logic [1:0] REG_REDUNDANCY   = 2'd2;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int RAND_W     = 32;
    localparam int LEN_W      = 32;
    localparam int MIN_W      = 16;
    localparam int DBL_W      = 5;
    localparam int RED_W      = 8;
    localparam int HEARD_W    = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [DBL_W-1:0]   MAX_DOUBLINGS = 5'd16;
    localparam logic [HEARD_W-1:0] HEARD_MAX     = 8'd255;

    // Effective configuration: minimum already forced nonzero, doublings capped
    typedef struct packed {
        logic [MIN_W-1:0] interval_min;
        logic [DBL_W-1:0] doublings;
        logic [RED_W-1:0] redundancy;
    } cfg_t;

    // One result word, packed in tdata order (transmit in bit 0)
    typedef struct packed {
        logic [LEN_W-1:0] current_interval;
        logic             running_now;
        logic             new_interval;
        logic             suppressed;
        logic             transmit;
    } result_t;

endpackage

// ===== rtl/trickle_timer_unit.sv =====
// Trickle timer top level: config registers, input register, core, result register.
// A result word is valid once its input word has passed the input and result registers.
// Throughput: one input word per cycle unless m_tready stalls; one state update per word.
// Backpressure: s_tready stays high while the result register can drain or is empty.
// Reset (rst_n low, asynchronous): timer stopped, interval 1 tick, counters zero,
// interval_min = 1, doublings = 0, redundancy = 0, no words held.
module trickle_timer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [trk_pkg::MIN_W-1:0]       cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [trk_pkg::IN_DATA_W-1:0]   s_tdata,   // [2:0] command, [34:3] random_word
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [trk_pkg::OUT_DATA_W-1:0]  m_tdata    // [0] transmit, [1] suppressed,
                                                       // [2] new_interval, [3] running_now,
                                                       // [35:4] current_interval
);

    trk_pkg::cfg_t                 cfg_reg;
    logic                          in_valid_reg;
    logic [trk_pkg::CMD_W-1:0]     command_reg;
    logic [trk_pkg::RAND_W-1:0]    random_word_reg;
    logic                          out_valid_reg;
    trk_pkg::result_t              out_reg;
    trk_pkg::result_t              result;
    logic                          advance;
    logic                          s_take;

    // Hold the configuration; store the minimum forced nonzero and doublings capped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_min <= trk_pkg::MIN_W'(1);
            cfg_reg.doublings    <= '0;
            cfg_reg.redundancy   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                trk_pkg::REG_INTERVAL_MIN:
                begin
                    cfg_reg.interval_min <= (cfg_data == '0) ? trk_pkg::MIN_W'(1) : cfg_data;
                end
                trk_pkg::REG_DOUBLINGS:
                begin
                    cfg_reg.doublings <= (cfg_data[trk_pkg::DBL_W-1:0] > trk_pkg::MAX_DOUBLINGS)
                                         ? trk_pkg::MAX_DOUBLINGS
                                         : cfg_data[trk_pkg::DBL_W-1:0];
                end
                trk_pkg::REG_REDUNDANCY:
                begin
                    cfg_reg.redundancy <= cfg_data[trk_pkg::RED_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Process the held word whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            command_reg     <= s_tdata[trk_pkg::CMD_W-1:0];
            random_word_reg <= s_tdata[trk_pkg::CMD_W+trk_pkg::RAND_W-1:trk_pkg::CMD_W];
        end
    end

    trk_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .command     (command_reg),
        .random_word (random_word_reg),
        .cfg         (cfg_reg),
        .result      (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(trk_pkg::OUT_DATA_W - $bits(trk_pkg::result_t))'(0), out_reg};

`ifndef SYNTH
    // Input side stalls only when both registers are full and the sink is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // A processed word always shows up as a result in the next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed word produced no result");

    // A fire event only happens on a running timer, and never both kinds at once
    a_fire_running: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_reg.transmit || out_reg.suppressed)) |->
        (out_reg.running_now && !(out_reg.transmit && out_reg.suppressed)))
        else $error("fire event on a stopped timer or both kinds");
`endif

endmodule

// ===== rtl/trk_fire.sv =====
// Fire point pick: half the interval plus a random share of the upper half.
module trk_fire
(
    input  logic [trk_pkg::LEN_W-1:0]  interval_len,
    input  logic [trk_pkg::RAND_W-1:0] random_word,
    output logic [trk_pkg::LEN_W-1:0]  fire_point
);

    logic [trk_pkg::LEN_W-1:0]                  half;
    logic [trk_pkg::LEN_W-1:0]                  span;
    logic [trk_pkg::LEN_W+trk_pkg::RAND_W-1:0] product;

    // Split the interval and scale the upper part by the random fraction
    assign half       = interval_len >> 1;
    assign span       = interval_len - half;
    assign product    = (trk_pkg::LEN_W+trk_pkg::RAND_W)'(random_word) *
                        (trk_pkg::LEN_W+trk_pkg::RAND_W)'(span);
    assign fire_point = half + product[trk_pkg::LEN_W+trk_pkg::RAND_W-1:trk_pkg::RAND_W];

endmodule

// ===== rtl/trk_core.sv =====
// Timer state and single-pass update for one command word.
module trk_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [trk_pkg::CMD_W-1:0]   command,
    input  logic [trk_pkg::RAND_W-1:0]  random_word,
    input  trk_pkg::cfg_t               cfg,
    output trk_pkg::result_t            result
);

    logic                          running_reg, running_next;
    logic [trk_pkg::LEN_W-1:0]     interval_len_reg, interval_len_next;
    logic [trk_pkg::LEN_W-1:0]     elapsed_reg, elapsed_next;
    logic [trk_pkg::LEN_W-1:0]     fire_point_reg, fire_point_next;
    logic [trk_pkg::HEARD_W-1:0]   heard_count_reg, heard_count_next;

    logic [trk_pkg::LEN_W-1:0]     len_min;
    logic [trk_pkg::LEN_W-1:0]     len_max;
    logic [trk_pkg::LEN_W:0]       len_double;
    logic [trk_pkg::LEN_W-1:0]     len_grown;
    logic [trk_pkg::LEN_W:0]       elapsed_inc;
    logic [trk_pkg::LEN_W-1:0]     fire_pick;
    logic                          fire_hit;
    logic                          quiet;
    logic                          begin_new;

    // Interval bounds from the effective configuration
    assign len_min    = trk_pkg::LEN_W'(cfg.interval_min);
    assign len_max    = len_min << cfg.doublings;
    assign len_double = {interval_len_reg, 1'b0};
    assign len_grown  = (len_double > {1'b0, len_max}) ? len_max
                                                       : len_double[trk_pkg::LEN_W-1:0];

    // Fire check and interval end for a tick
    assign fire_hit    = (elapsed_reg == fire_point_reg);
    assign quiet       = (cfg.redundancy != '0) && (heard_count_reg >= cfg.redundancy);
    assign elapsed_inc = {1'b0, elapsed_reg} + 1'b1;

    trk_fire u_fire
    (
        .interval_len (interval_len_next),
        .random_word  (random_word),
        .fire_point   (fire_pick)
    );

    // Decode the command into next state and result
    always_comb
    begin
        running_next      = running_reg;
        interval_len_next = interval_len_reg;
        heard_count_next  = heard_count_reg;
        begin_new         = 1'b0;
        result.transmit   = 1'b0;
        result.suppressed = 1'b0;
        case (command)
            trk_pkg::CMD_TICK:
            begin
                if (running_reg)
                begin
                    result.transmit   = fire_hit && !quiet;
                    result.suppressed = fire_hit && quiet;
                    if (elapsed_inc >= {1'b0, interval_len_reg})
                    begin
                        interval_len_next = len_grown;
                        begin_new         = 1'b1;
                    end
                end
            end
            trk_pkg::CMD_START:
            begin
                running_next      = 1'b1;
                interval_len_next = len_min;
                begin_new         = 1'b1;
            end
            trk_pkg::CMD_STOP:
            begin
                running_next = 1'b0;
            end
            trk_pkg::CMD_INCONSISTENT:
            begin
                if (running_reg && (interval_len_reg != len_min))
                begin
                    interval_len_next = len_min;
                    begin_new         = 1'b1;
                end
            end
            trk_pkg::CMD_CONSISTENT:
            begin
                if (heard_count_reg != trk_pkg::HEARD_MAX)
                begin
                    heard_count_next = heard_count_reg + 1'b1;
                end
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase

        // Advance time on a running tick, restart counters on a new interval
        elapsed_next    = elapsed_reg;
        fire_point_next = fire_point_reg;
        if (command == trk_pkg::CMD_TICK && running_reg)
        begin
            elapsed_next = elapsed_inc[trk_pkg::LEN_W-1:0];
        end
        if (begin_new)
        begin
            elapsed_next     = '0;
            heard_count_next = '0;
            fire_point_next  = fire_pick;
        end

        result.new_interval     = begin_new;
        result.running_now      = running_next;
        result.current_interval = interval_len_next;
    end

    // Commit state when a word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            interval_len_reg <= trk_pkg::LEN_W'(1);
            elapsed_reg      <= '0;
            fire_point_reg   <= '0;
            heard_count_reg  <= '0;
        end
        else if (step)
        begin
            running_reg      <= running_next;
            interval_len_reg <= interval_len_next;
            elapsed_reg      <= elapsed_next;
            fire_point_reg   <= fire_point_next;
            heard_count_reg  <= heard_count_next;
        end
    end

`ifndef SYNTH
    // Elapsed time always stays inside the current interval
    a_elapsed_in_interval: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg < interval_len_reg)
        else $error("elapsed count reached interval length");

    // Fire point always lies inside the current interval
    a_fire_in_interval: assert property (@(posedge clk) disable iff (!rst_n)
        fire_point_reg < interval_len_reg)
        else $error("fire point outside interval");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the trickle timer unit: stream driver, result monitor, predictor.
module testbench;
    import trk_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT    = 7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [MIN_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor copy of the registers and the timer state
    logic [MIN_W-1:0]      min_reg;
    logic [DBL_W-1:0]      dbl_reg;
    logic [RED_W-1:0]      red_reg;
    logic                  tmr_running;
    logic [LEN_W-1:0]      interval_ticks;
    logic [LEN_W-1:0]      elapsed_ticks;
    logic [LEN_W-1:0]      fire_at;
    logic [HEARD_W-1:0]    heard;

    logic [IN_DATA_W-1:0]  pending_words[$];
    result_t               expected_results[$];

    logic                  steady = 1'b0;
    int                    errors = 0;
    int                    cycles = 0;
    int                    words_sent = 0;
    int                    results_seen = 0;
    int                    sent_tx = 0;
    int                    sent_sup = 0;
    int                    fresh_count = 0;
    int                    settings_used = 1;
    int                    stall_left = 0;
    logic                  stall_done = 1'b0;

    trickle_timer_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [LEN_W-1:0] min_interval();
        return (min_reg == '0) ? 32'd1 : {16'd0, min_reg};
    endfunction

    function automatic logic [LEN_W-1:0] max_interval();
        logic [DBL_W-1:0] shift;
        shift = (dbl_reg > MAX_DOUBLINGS) ? MAX_DOUBLINGS : dbl_reg;
        return min_interval() << shift;
    endfunction

    // Clear the heard count and place the fire point in [I/2, I)
    task automatic open_interval(input logic [RAND_W-1:0] rnd);
        logic [LEN_W-1:0] half;
        logic [63:0]      prod;
        half          = interval_ticks >> 1;
        prod          = {32'd0, rnd} * {32'd0, interval_ticks - half};
        heard         = '0;
        elapsed_ticks = '0;
        fire_at       = half + prod[63:32];
    endtask

    // Advance the predicted timer by one accepted word and queue its result
    task automatic advance_timer(input logic [IN_DATA_W-1:0] word);
        logic [CMD_W-1:0]  cmd;
        logic [RAND_W-1:0] rnd;
        logic [LEN_W:0]    doubled;
        logic [LEN_W-1:0]  cap;
        result_t           r;
        cmd = word[CMD_W-1:0];
        rnd = word[CMD_W+RAND_W-1:CMD_W];
        r   = '0;
        case (cmd)
            CMD_TICK:
            begin
                if (tmr_running)
                begin
                    if (elapsed_ticks == fire_at)
                    begin
                        if (red_reg != '0 && heard >= red_reg)
                            r.suppressed = 1'b1;
                        else
                            r.transmit = 1'b1;
                    end
                    elapsed_ticks = elapsed_ticks + 1;
                    if (elapsed_ticks >= interval_ticks)
                    begin
                        doubled        = {interval_ticks, 1'b0};
                        cap            = max_interval();
                        interval_ticks = (doubled > {1'b0, cap}) ? cap : doubled[LEN_W-1:0];
                        open_interval(rnd);
                        r.new_interval = 1'b1;
                    end
                end
            end
            CMD_START:
            begin
                tmr_running    = 1'b1;
                interval_ticks = min_interval();
                open_interval(rnd);
                r.new_interval = 1'b1;
            end
            CMD_STOP:
                tmr_running = 1'b0;
            CMD_INCONSISTENT:
            begin
                if (tmr_running && interval_ticks != min_interval())
                begin
                    interval_ticks = min_interval();
                    open_interval(rnd);
                    r.new_interval = 1'b1;
                end
            end
            CMD_CONSISTENT:
            begin
                if (heard != HEARD_MAX)
                    heard = heard + 1'b1;
            end
            default: ;
        endcase
        r.running_now      = tmr_running;
        r.current_interval = interval_ticks;
        expected_results.push_back(r);
        words_sent  += 1;
        sent_tx     += int'(r.transmit);
        sent_sup    += int'(r.suppressed);
        fresh_count += int'(r.new_interval);
    endtask

    task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors += 1;
        end
    endtask

    // Driver: offer queued words, idling now and then
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                advance_timer(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    s_tdata  <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure plus one long hold while words are still queued
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!stall_done && results_seen > 60 && pending_words.size() >= 40)
        begin
            m_tready   <= 1'b0;
            stall_left <= 80;
            stall_done <= 1'b1;
        end
        else
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(result_t)-1:0];
            if (expected_results.size() == 0)
            begin
                $error("result word 0x%h arrived with nothing predicted", m_tdata);
                errors += 1;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("transmit", LEN_W'(want.transmit), LEN_W'(got.transmit));
                check_field("suppressed", LEN_W'(want.suppressed), LEN_W'(got.suppressed));
                check_field("new_interval", LEN_W'(want.new_interval),
                            LEN_W'(got.new_interval));
                check_field("running_now", LEN_W'(want.running_now), LEN_W'(got.running_now));
                check_field("current_interval", want.current_interval, got.current_interval);
            end
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [RAND_W-1:0] rnd);
        pending_words.push_back({5'd0, rnd, cmd});
    endtask

    // Mostly ticks, with heard events, restarts, stops and unknown codes mixed in
    task automatic queue_random(input int count);
        int unsigned      pick;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                cmd = CMD_TICK;
            else if (pick < 70)
                cmd = CMD_CONSISTENT;
            else if (pick < 80)
                cmd = CMD_INCONSISTENT;
            else if (pick < 88)
                cmd = CMD_START;
            else if (pick < 94)
                cmd = CMD_STOP;
            else
                cmd = CMD_W'($urandom_range(5, 7));
            queue_word(cmd, $urandom);
        end
    endtask

    // Hold until every queued word is sent and every result has come back
    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [MIN_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INTERVAL_MIN: min_reg = val;
            REG_DOUBLINGS:    dbl_reg = val[DBL_W-1:0];
            REG_REDUNDANCY:   red_reg = val[RED_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_timer(input logic [MIN_W-1:0] imin, input logic [MIN_W-1:0] dbl,
                             input logic [MIN_W-1:0] red);
        write_reg(REG_INTERVAL_MIN, imin);
        write_reg(REG_DOUBLINGS, dbl);
        write_reg(REG_REDUNDANCY, red);
        settings_used += 1;
    endtask

    initial
    begin
        min_reg        = 16'd1;
        dbl_reg        = '0;
        red_reg        = '0;
        tmr_running    = 1'b0;
        interval_ticks = 32'd1;
        elapsed_ticks  = '0;
        fire_at        = '0;
        heard          = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: commands while stopped, unknown codes, one-tick interval
        queue_word(CMD_TICK, 32'd0);
        queue_word(CMD_STOP, 32'd0);
        queue_word(CMD_INCONSISTENT, 32'hFFFF_FFFF);
        queue_word(CMD_CONSISTENT, 32'd0);
        queue_word(3'd5, 32'hFFFF_FFFF);
        queue_word(3'd7, 32'd0);
        queue_word(CMD_START, 32'd0);
        queue_word(CMD_TICK, 32'hFFFF_FFFF);
        queue_word(CMD_TICK, 32'd0);
        queue_word(CMD_INCONSISTENT, 32'hFFFF_FFFF);
        queue_word(CMD_START, 32'hFFFF_FFFF);
        queue_word(CMD_STOP, 32'd0);
        queue_word(CMD_TICK, 32'd0);
        drain();

        // Widest settings: largest minimum and doublings, full redundancy
        set_timer(16'hFFFF, 16'd16, 16'd255);
        queue_word(CMD_START, 32'hFFFF_FFFF);
        queue_word(CMD_TICK, 32'd0);
        queue_word(CMD_INCONSISTENT, 32'd0);
        queue_word(CMD_STOP, 32'd0);
        drain();

        // Zero minimum counts as one, excess doublings capped, suppression at k = 1
        set_timer(16'd0, 16'd31, 16'd1);
        queue_word(CMD_START, 32'd0);
        repeat (4) queue_word(CMD_TICK, $urandom);
        queue_word(CMD_CONSISTENT, 32'd0);
        repeat (3) queue_word(CMD_TICK, $urandom);
        queue_word(CMD_INCONSISTENT, $urandom);
        queue_word(CMD_TICK, $urandom);
        queue_random(70);
        drain();

        // Short intervals with no idling on either side
        set_timer(16'd3, 16'd3, 16'd2);
        steady = 1'b1;
        queue_word(CMD_START, $urandom);
        queue_random(90);
        drain();
        steady = 1'b0;

        // Grow the interval to 20 ticks, then shrink the maximum under it
        set_timer(16'd5, 16'd2, 16'd0);
        queue_random(30);
        queue_word(CMD_START, $urandom);
        repeat (15) queue_word(CMD_TICK, $urandom);
        drain();
        set_timer(16'd2, 16'd1, 16'd3);
        repeat (25) queue_word(CMD_TICK, $urandom);
        queue_random(30);
        drain();

        // Saturate the heard count, then reach the fire point at k = 255
        set_timer(16'd4, 16'd0, 16'd255);
        queue_word(CMD_START, $urandom);
        repeat (258) queue_word(CMD_CONSISTENT, $urandom);
        repeat (4) queue_word(CMD_TICK, $urandom);
        drain();

        repeat (8) @(posedge clk);
        $display("Sent %0d timer commands under %0d register settings, checked %0d results.",
                 words_sent, settings_used, results_seen);
        $display("Fire points: %0d transmitted, %0d suppressed; %0d new intervals begun.",
                 sent_tx, sent_sup, fresh_count);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== trickle_timer_unit.f =====
rtl/trk_pkg.sv
rtl/trk_fire.sv
rtl/trk_core.sv
rtl/trickle_timer_unit.sv
tb/sv/testbench.sv
